[rtl/ufrc_pkg.sv]
`timescale 1ns / 1ps

package ufrc_pkg;

   // index width of the channels and width of the rank table
   localparam int IDX_W = 10;
   localparam int RANK_W = 4;

   // largest table that the index width can reach
   localparam int MAX_DEPTH = 2 ** IDX_W;
   localparam int N_ENTRIES_DEF = 1024;

   localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

   // opcodes
   localparam logic OP_FIND = 1'b0;
   localparam logic OP_UNITE = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] second_index;
      logic             out_of_range;
   } ufrc_item_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_COMP,
      ST_PICK,
      ST_RANK_A,
      ST_RANK_B,
      ST_DONE
   } ufrc_state_type;

endpackage

[rtl/ufrc_ifs.sv]
`timescale 1ns / 1ps

// request channel: one beat per find or unite
interface ufrc_req_if;
   import ufrc_pkg::*;

   logic             valid;
   logic             ready;
   logic             opcode;
   logic [IDX_W-1:0] first_index;
   logic [IDX_W-1:0] second_index;

   modport source (output valid, output opcode, output first_index, output second_index,
                   input ready);
   modport sink (input valid, input opcode, input first_index, input second_index,
                 output ready);
endinterface

// response channel: one beat per request
interface ufrc_rsp_if;
   import ufrc_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] root_of_first;
   logic             sets_merged;

   modport source (output valid, output root_of_first, output sets_merged, input ready);
   modport sink (input valid, input root_of_first, input sets_merged, output ready);
endinterface

[rtl/ufrc_ram.sv]
`timescale 1ns / 1ps

module ufrc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/ufrc_front.sv]
`timescale 1ns / 1ps

module ufrc_front #(
   parameter int N_ENTRIES = ufrc_pkg::N_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ufrc_req_if.sink               req,
   input  logic                   back_clearing,
   output logic                   q_valid,
   input  logic                   q_pop,
   output ufrc_pkg::ufrc_item_type q_item
);
   import ufrc_pkg::*;

   ufrc_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;
   ufrc_item_type new_item;

   // classify the incoming beat
   always_comb begin
      new_item.opcode = req.opcode;
      new_item.first_index = req.first_index;
      new_item.second_index = req.second_index;
      new_item.out_of_range = (32'(req.first_index) >= N_ENTRIES) ||
                              ((req.opcode == OP_UNITE) && (32'(req.second_index) >= N_ENTRIES));
   end

   // no beats during the table clearing pass
   assign req.ready = (count_ff != 2'd2) && !back_clearing;
   assign push = req.valid && req.ready;

   assign q_valid = (count_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];

   // two entry queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/ufrc_back.sv]
`timescale 1ns / 1ps

module ufrc_back #(
   parameter int N_ENTRIES = ufrc_pkg::N_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  ufrc_pkg::ufrc_item_type q_item,
   output logic                    back_clearing,
   ufrc_rsp_if.source              rsp
);
   import ufrc_pkg::*;

   localparam int DEPTH = (N_ENTRIES < MAX_DEPTH) ? N_ENTRIES : MAX_DEPTH;
   localparam int AW = $clog2(DEPTH);

   ufrc_state_type   state_ff, state_in;
   ufrc_item_type    item_ff, item_in;
   logic             phase_ff, phase_in;
   logic [AW-1:0]    start_ff, start_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    root_ff, root_in;
   logic [AW-1:0]    ra_ff, ra_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0] res_root_ff, res_root_in;
   logic             res_merged_ff, res_merged_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_root_ff;
   logic             rsp_merged_ff;
   logic             rsp_load;

   logic              p_we, r_we;
   logic [AW-1:0]     p_waddr, p_raddr, r_waddr, r_raddr;
   logic [AW-1:0]     p_wdata, p_rdata;
   logic [RANK_W-1:0] r_wdata, r_rdata;

   ufrc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_parent (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata)
   );

   ufrc_ram #(.WIDTH(RANK_W), .DEPTH(DEPTH)) u_rank (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(r_raddr), .rdata(r_rdata)
   );

   assign back_clearing = (state_ff == ST_CLEAR);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) state_in = q_item.out_of_range ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (p_rdata == cur_ff) state_in = (start_ff == cur_ff) ? ST_PICK : ST_COMP;
         end
         ST_COMP: begin
            if (p_rdata == root_ff) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (!phase_ff) begin
               state_in = (item_ff.opcode == OP_UNITE) ? ST_WALK : ST_DONE;
            end else begin
               state_in = (root_ff == ra_ff) ? ST_DONE : ST_RANK_A;
            end
         end
         ST_RANK_A: state_in = ST_RANK_B;
         ST_RANK_B: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table ports
   always_comb begin
      item_in = item_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      cur_in = cur_ff;
      root_in = root_ff;
      ra_in = ra_ff;
      rank_a_in = rank_a_ff;
      clr_in = clr_ff;
      res_root_in = res_root_ff;
      res_merged_in = res_merged_ff;
      q_pop = 1'b0;
      p_we = 1'b0;
      p_waddr = cur_ff;
      p_wdata = root_ff;
      p_raddr = cur_ff;
      r_we = 1'b0;
      r_waddr = root_ff;
      r_wdata = '0;
      r_raddr = root_ff;
      case (state_ff)
         // every entry its own parent, rank zero
         ST_CLEAR: begin
            p_we = 1'b1;
            p_waddr = clr_ff;
            p_wdata = clr_ff;
            r_we = 1'b1;
            r_waddr = clr_ff;
            r_wdata = '0;
            clr_in = clr_ff + 1'b1;
         end
         // take the next item and, if it is in range, start the first walk
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               item_in = q_item;
               phase_in = 1'b0;
               start_in = q_item.first_index[AW-1:0];
               cur_in = q_item.first_index[AW-1:0];
               p_raddr = q_item.first_index[AW-1:0];
               res_root_in = q_item.first_index;
               res_merged_in = 1'b0;
            end
         end
         // follow parent links until an entry points at itself
         ST_WALK: begin
            if (p_rdata == cur_ff) begin
               root_in = cur_ff;
               cur_in = start_ff;
               p_raddr = start_ff;
            end else begin
               cur_in = p_rdata;
               p_raddr = p_rdata;
            end
         end
         // repoint each entry on the path at the root
         ST_COMP: begin
            p_we = 1'b1;
            p_waddr = cur_ff;
            p_wdata = root_ff;
            cur_in = p_rdata;
            p_raddr = p_rdata;
         end
         // decide after each walk
         ST_PICK: begin
            if (!phase_ff) begin
               ra_in = root_ff;
               res_root_in = IDX_W'(root_ff);
               res_merged_in = 1'b0;
               phase_in = 1'b1;
               start_in = item_ff.second_index[AW-1:0];
               cur_in = item_ff.second_index[AW-1:0];
               p_raddr = item_ff.second_index[AW-1:0];
            end else begin
               r_raddr = ra_ff;
            end
         end
         // rank of the first root lands, fetch the second
         ST_RANK_A: begin
            rank_a_in = r_rdata;
            r_raddr = root_ff;
         end
         // link by rank
         ST_RANK_B: begin
            res_merged_in = 1'b1;
            p_we = 1'b1;
            if (rank_a_ff < r_rdata) begin
               p_waddr = ra_ff;
               p_wdata = root_ff;
               res_root_in = IDX_W'(root_ff);
            end else begin
               p_waddr = root_ff;
               p_wdata = ra_ff;
               res_root_in = IDX_W'(ra_ff);
               if ((rank_a_ff == r_rdata) && (rank_a_ff != RANK_MAX)) begin
                  r_we = 1'b1;
                  r_waddr = ra_ff;
                  r_wdata = rank_a_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      phase_ff <= phase_in;
      start_ff <= start_in;
      cur_ff <= cur_in;
      root_ff <= root_in;
      ra_ff <= ra_in;
      rank_a_ff <= rank_a_in;
      res_root_ff <= res_root_in;
      res_merged_ff <= res_merged_in;
      if (rsp_load) begin
         rsp_root_ff <= res_root_ff;
         rsp_merged_ff <= res_merged_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.root_of_first = rsp_root_ff;
   assign rsp.sets_merged = rsp_merged_ff;

endmodule

[rtl/union_find_rank_compress.sv]
`timescale 1ns / 1ps

// Disjoint-set table with union by rank and path compression. A find walks from
// first_index to its root and repoints the path at the root; a unite does the same
// for both indices, then links the lower-rank root under the other (on equal ranks
// the second root goes under the first, whose rank rises and saturates at 15).
// Each request beat gives one response beat: root_of_first and sets_merged. An
// index at or above N_ENTRIES leaves the table untouched and returns first_index.
// Timing is set by the single read port of the parent memory, whose read data is
// registered: each walk reads one link at a time on its way to the root, then
// repoints the path one entry at a time; out-of-range requests skip the table.
// A stalled response holds the next result in the back end until it is taken.
// After reset the block runs a clearing pass over min(N_ENTRIES, 1024) entries
// with req.ready low.
// A two-entry queue takes requests while the table work runs, and a response
// register holds a finished result while the next request is already worked on.
module union_find_rank_compress #(
   parameter int N_ENTRIES = ufrc_pkg::N_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ufrc_req_if.sink   req,
   ufrc_rsp_if.source rsp
);
   import ufrc_pkg::*;

   logic          q_valid;
   logic          q_pop;
   ufrc_item_type q_item;
   logic          back_clearing;

   ufrc_front #(.N_ENTRIES(N_ENTRIES)) u_front (
      .clock(clock),
      .reset(reset),
      .req(req),
      .back_clearing(back_clearing),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_item(q_item)
   );

   ufrc_back #(.N_ENTRIES(N_ENTRIES)) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_item(q_item),
      .back_clearing(back_clearing),
      .rsp(rsp)
   );

endmodule

[rtl/ufrc_checker.sv]
`timescale 1ns / 1ps

module ufrc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ufrc_pkg::IDX_W-1:0]  rsp_root_of_first,
   input logic                        rsp_sets_merged
);
   import ufrc_pkg::*;

   // table is cleared after reset, so no request is taken right away
   a_no_req_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // no response comes out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_root_of_first) && $stable(rsp_sets_merged))
      else $error("response payload changed while stalled");

endmodule

bind union_find_rank_compress ufrc_checker u_ufrc_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_root_of_first(rsp.root_of_first),
   .rsp_sets_merged(rsp.sets_merged)
);

[tb/tb_union_find_rank_compress.sv]
`timescale 1ns / 1ps

module tb_union_find_rank_compress;
   import ufrc_pkg::*;

   localparam int TABLE_DEPTH = N_ENTRIES_DEF;
   localparam int LONG_HOLD = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_TARGET = 850;
   localparam int DIR_COUNT = 20;

   // one request beat, optionally with the response it must give
   typedef struct packed {
      logic             known;
      logic             opcode;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] second_index;
      logic [IDX_W-1:0] root_of_first;
      logic             sets_merged;
   } req_row_type;

   typedef struct packed {
      logic [IDX_W-1:0] root_of_first;
      logic             sets_merged;
   } root_result_type;

   // directed rows: fresh table, extremes, all three rank cases, same-set unite,
   // a small binomial tree and a deep find that flattens it
   localparam req_row_type DIR_ROWS [DIR_COUNT] = '{
      '{1'b1, OP_FIND,  10'h000, 10'h000, 10'h000, 1'b0},
      '{1'b1, OP_FIND,  10'h3FF, 10'h000, 10'h3FF, 1'b0},
      '{1'b1, OP_FIND,  10'h155, 10'h2AA, 10'h155, 1'b0},
      '{1'b1, OP_FIND,  10'h2AA, 10'h155, 10'h2AA, 1'b0},
      '{1'b1, OP_UNITE, 10'h000, 10'h3FF, 10'h000, 1'b1},
      '{1'b1, OP_UNITE, 10'h3FF, 10'h000, 10'h000, 1'b0},
      '{1'b1, OP_FIND,  10'h3FF, 10'h155, 10'h000, 1'b0},
      '{1'b1, OP_UNITE, 10'h007, 10'h007, 10'h007, 1'b0},
      '{1'b1, OP_UNITE, 10'h005, 10'h000, 10'h000, 1'b1},
      '{1'b1, OP_UNITE, 10'h3FF, 10'h155, 10'h000, 1'b1},
      '{1'b0, OP_UNITE, 10'h3E0, 10'h3E1, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E2, 10'h3E3, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E4, 10'h3E5, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E6, 10'h3E7, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E0, 10'h3E2, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E4, 10'h3E6, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E0, 10'h3E4, 10'h000, 1'b0},
      '{1'b0, OP_FIND,  10'h3E7, 10'h2AA, 10'h000, 1'b0},
      '{1'b0, OP_UNITE, 10'h3E7, 10'h000, 10'h000, 1'b0},
      '{1'b0, OP_FIND,  10'h3FF, 10'h001, 10'h000, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   ufrc_req_if req_bus ();
   ufrc_rsp_if rsp_bus ();

   union_find_rank_compress #(
      .N_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   always #2 clock = ~clock;

   // shadow of the disjoint-set table
   logic [IDX_W-1:0]  link_tbl [TABLE_DEPTH];
   logic [RANK_W-1:0] rank_tbl [TABLE_DEPTH];

   root_result_type root_q [$];
   req_row_type     cur_row;
   int              fail_count = 0;
   int              beats_sent = 0;
   int              idle_cycles = 0;
   bit              no_idle = 1'b0;
   bit              hold_rsp = 1'b0;

   // walk to the root, then point the whole path straight at it
   function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] e);
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] nxt;
      int steps;
      r = e;
      steps = 0;
      while (link_tbl[r] != r && steps < TABLE_DEPTH) begin
         r = link_tbl[r];
         steps++;
      end
      steps = 0;
      while (e != r && steps < TABLE_DEPTH) begin
         nxt = link_tbl[e];
         link_tbl[e] = r;
         e = nxt;
         steps++;
      end
      return r;
   endfunction

   // find or unite by rank, returns the response the block must give
   function automatic root_result_type apply_request(input logic op,
                                                     input logic [IDX_W-1:0] a,
                                                     input logic [IDX_W-1:0] b);
      root_result_type res;
      logic [IDX_W-1:0] ra;
      logic [IDX_W-1:0] rb;
      res.root_of_first = a;
      res.sets_merged = 1'b0;
      if (int'(a) >= TABLE_DEPTH || (op == OP_UNITE && int'(b) >= TABLE_DEPTH))
         return res;
      ra = find_root(a);
      if (op == OP_UNITE) begin
         rb = find_root(b);
         if (ra != rb) begin
            res.sets_merged = 1'b1;
            if (rank_tbl[ra] < rank_tbl[rb]) begin
               link_tbl[ra] = rb;
               ra = rb;
            end else if (rank_tbl[ra] > rank_tbl[rb]) begin
               link_tbl[rb] = ra;
            end else begin
               link_tbl[rb] = ra;
               if (rank_tbl[ra] != RANK_MAX)
                  rank_tbl[ra] = rank_tbl[ra] + 1'b1;
            end
         end
      end
      res.root_of_first = ra;
      return res;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : int'($urandom_range(0, 6));
   endfunction

   function automatic req_row_type mk_row(input logic op, input int a, input int b);
      req_row_type row;
      row = '0;
      row.opcode = op;
      row.first_index = a[IDX_W-1:0];
      row.second_index = b[IDX_W-1:0];
      return row;
   endfunction

   // random find or unite inside [base, base + span), second index anywhere on a find
   function automatic req_row_type rand_row(input int base, input int span, input int unite_pct);
      logic op;
      int a;
      int b;
      op = ($urandom_range(0, 99) < unite_pct) ? OP_UNITE : OP_FIND;
      a = base + int'($urandom_range(0, span - 1));
      if (op == OP_UNITE)
         b = base + int'($urandom_range(0, span - 1));
      else
         b = int'($urandom_range(0, TABLE_DEPTH - 1));
      return mk_row(op, a, b);
   endfunction

   // offer one request beat and wait for it to be taken
   task automatic send_req(input req_row_type row);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_row = row;
      req_bus.valid <= 1'b1;
      req_bus.opcode <= row.opcode;
      req_bus.first_index <= row.first_index;
      req_bus.second_index <= row.second_index;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
      beats_sent++;
   endtask

   // stop offering until every pending response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (root_q.size() != 0) @(negedge clock);
   endtask

   // binomial tree of 2**k entries at an aligned base, then mostly finds inside it
   task automatic build_tree(input int k);
      int size;
      int base;
      int s;
      int i;
      size = 1 << k;
      base = int'($urandom_range(0, (TABLE_DEPTH >> k) - 1)) << k;
      for (s = 1; s < size; s = s * 2) begin
         for (i = 0; i < size; i = i + 2 * s) begin
            if ($urandom_range(0, 3) == 0)
               send_req(mk_row(OP_UNITE, base + i + s, base + i));
            else
               send_req(mk_row(OP_UNITE, base + i, base + i + s));
         end
      end
      repeat (size / 2 + 1) send_req(rand_row(base, size, 10));
   endtask

   // predict on request beats, check on response beats
   always @(posedge clock) begin
      root_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            link_tbl[i] = i[IDX_W-1:0];
            rank_tbl[i] = '0;
         end
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            want = apply_request(req_bus.opcode, req_bus.first_index, req_bus.second_index);
            if (cur_row.known) begin
               want.root_of_first = cur_row.root_of_first;
               want.sets_merged = cur_row.sets_merged;
            end
            root_q = {root_q, want};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (root_q.size() == 0) begin
               $error("response beat with no request pending");
               fail_count++;
            end else begin
               want = root_q.pop_front();
               if (rsp_bus.root_of_first !== want.root_of_first) begin
                  $error("root_of_first: expected %0d, got %0d",
                         want.root_of_first, rsp_bus.root_of_first);
                  fail_count++;
               end
               if (rsp_bus.sets_merged !== want.sets_merged) begin
                  $error("sets_merged: expected %0d, got %0d",
                         want.sets_merged, rsp_bus.sets_merged);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            stall = LONG_HOLD;
            hold_rsp = 1'b0;
         end else begin
            stall = draw_gap();
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         @(negedge clock);
      end
   end

   // request side
   initial begin
      int span;
      cur_row = '0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_FIND;
      req_bus.first_index <= '0;
      req_bus.second_index <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < DIR_COUNT; i++) send_req(DIR_ROWS[i]);

      // random finds and unites over pools of several sizes
      repeat (250) begin
         case ($urandom_range(0, 2))
            0: span = 16;
            1: span = 64;
            default: span = TABLE_DEPTH;
         endcase
         send_req(rand_row(int'($urandom_range(0, TABLE_DEPTH - span)), span, 55));
      end

      // receiver holds off while requests keep coming, block fills up
      hold_rsp = 1'b1;
      no_idle = 1'b1;
      repeat (24) send_req(rand_row(0, TABLE_DEPTH, 50));
      no_idle = 1'b0;
      wait_drained();

      // deep trees built by rank, then flattened by finds
      while (beats_sent < 560) build_tree(int'($urandom_range(1, 5)));

      // back-to-back beats on a small pool
      no_idle = 1'b1;
      repeat (100) send_req(rand_row(int'($urandom_range(0, TABLE_DEPTH - 16)), 16, 50));
      no_idle = 1'b0;
      wait_drained();

      // noise over the whole table
      while (beats_sent < ITEM_TARGET) send_req(rand_row(0, TABLE_DEPTH, 50));

      wait_drained();
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[union_find_rank_compress.f]
rtl/ufrc_pkg.sv
rtl/ufrc_ifs.sv
rtl/ufrc_ram.sv
rtl/ufrc_front.sv
rtl/ufrc_back.sv
rtl/union_find_rank_compress.sv
rtl/ufrc_checker.sv
tb/tb_union_find_rank_compress.sv
